/* rtl/rob_pkg.sv */
// Package with the constants and stage payload types of the RGBA over blend unit.
package rob_pkg;

    // Byte width of one color channel or alpha value.
    localparam int CHAN_W = 8;
    // Number of color lanes (red, green, blue); alpha is handled apart.
    localparam int NUM_LANES = 3;
    // Width of a pixel word.
    localparam int PIX_W = 32;
    // Width of a 255-scaled alpha weight.
    localparam int WGT_W = 16;
    // Width of the composite denominator, at most 65025.
    localparam int DEN_W = 17;
    // Width of a color numerator, at most 255 times the denominator.
    localparam int NUM_W = 25;
    // Quotient bits resolved by each divider stage.
    localparam int BITS_PER_STAGE = 2;
    // Number of divider stages needed for an eight-bit quotient.
    localparam int DIV_STAGES = CHAN_W / BITS_PER_STAGE;

    // Payload after the weight stage: alpha weights, denominator and raw colors.
    typedef struct packed {
        logic [WGT_W-1:0]                   top_wgt;
        logic [WGT_W-1:0]                   bot_wgt;
        logic [DEN_W-1:0]                   den;
        logic [NUM_LANES-1:0][CHAN_W-1:0]   top_col;
        logic [NUM_LANES-1:0][CHAN_W-1:0]   bot_col;
    } wgt_stage_t;

    // Payload of the numerator stage and of every divider stage.
    typedef struct packed {
        logic [NUM_LANES-1:0][NUM_W-1:0]    rem;
        logic [NUM_LANES-1:0][CHAN_W-1:0]   quo;
        logic [DEN_W-1:0]                   den;
        logic [CHAN_W-1:0]                  alpha;
    } div_stage_t;

endpackage

/* rtl/rgba_over_blend_unit.sv */
// Top level of the RGBA over blend unit: a pipelined Porter-Duff over composite.
// Throughput is one pixel pair per cycle while the sink keeps m_ready high;
// the valid bit of every stage travels with its data.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles are squeezed out.
// The color divisions use four restoring divider stages that resolve two quotient bits each.
// Reset (aresetn low at a clock edge) empties every stage; no payload is cleared.
module rgba_over_blend_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rob_pkg::PIX_W-1:0]   s_top_pixel,
    input  logic [rob_pkg::PIX_W-1:0]   s_bottom_pixel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rob_pkg::PIX_W-1:0]   m_blended_pixel
);
    import rob_pkg::*;

    logic                   wgt_valid_reg;
    wgt_stage_t             wgt_reg;
    wgt_stage_t             wgt_next;
    logic                   wgt_ready;

    logic                   num_valid_reg;
    div_stage_t             num_reg;
    div_stage_t             num_next;
    logic                   num_ready;

    logic                   div_valid_reg [DIV_STAGES];
    div_stage_t             div_reg [DIV_STAGES];
    div_stage_t             div_next [DIV_STAGES];
    logic                   div_ready [DIV_STAGES];

    logic                   m_valid_reg;
    logic [PIX_W-1:0]       m_blended_pixel_reg;
    logic [PIX_W-1:0]       m_blended_pixel_next;
    logic                   out_ready;

    // A stage may load when it is empty or its beat moves on in this cycle.
    assign out_ready = !m_valid_reg || m_ready;

    generate
        for (genvar g = 0; g < DIV_STAGES; g++) begin : g_ready
            if (g == DIV_STAGES - 1) begin : g_last
                assign div_ready[g] = !div_valid_reg[g] || out_ready;
            end else begin : g_mid
                assign div_ready[g] = !div_valid_reg[g] || div_ready[g+1];
            end
        end
    endgenerate

    assign num_ready = !num_valid_reg || div_ready[0];
    assign wgt_ready = !wgt_valid_reg || num_ready;
    assign s_ready   = wgt_ready;

    // Weight stage: 255*sa, da*(255-sa) and their sum, the denominator.
    always_comb begin
        logic [CHAN_W-1:0] sa;
        logic [CHAN_W-1:0] da;
        sa = s_top_pixel[PIX_W-1 -: CHAN_W];
        da = s_bottom_pixel[PIX_W-1 -: CHAN_W];
        wgt_next.top_wgt = {sa, {CHAN_W{1'b0}}} - WGT_W'(sa);
        wgt_next.bot_wgt = WGT_W'(da) * (WGT_W'({CHAN_W{1'b1}}) - WGT_W'(sa));
        wgt_next.den     = DEN_W'(wgt_next.top_wgt) + DEN_W'(wgt_next.bot_wgt);
        for (int i = 0; i < NUM_LANES; i++) begin
            wgt_next.top_col[i] = s_top_pixel[i*CHAN_W +: CHAN_W];
            wgt_next.bot_col[i] = s_bottom_pixel[i*CHAN_W +: CHAN_W];
        end
    end

    // Numerator stage: weighted color sums per lane, and alpha as den/255.
    always_comb begin
        logic [WGT_W+CHAN_W-1:0] top_prod;
        logic [WGT_W+CHAN_W-1:0] bot_prod;
        logic [DEN_W:0]          alpha_sum;
        top_prod = '0;
        bot_prod = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            top_prod        = (WGT_W+CHAN_W)'(wgt_reg.top_wgt)
                            * (WGT_W+CHAN_W)'(wgt_reg.top_col[i]);
            bot_prod        = (WGT_W+CHAN_W)'(wgt_reg.bot_wgt)
                            * (WGT_W+CHAN_W)'(wgt_reg.bot_col[i]);
            num_next.rem[i] = NUM_W'(top_prod) + NUM_W'(bot_prod);
            num_next.quo[i] = '0;
        end
        num_next.den = wgt_reg.den;
        // Exact floor(x/255) for x below 65535: (x + (x >> 8) + 1) >> 8.
        alpha_sum = (DEN_W+1)'(wgt_reg.den) + (DEN_W+1)'(wgt_reg.den[DEN_W-1:CHAN_W])
                  + (DEN_W+1)'(1);
        num_next.alpha = alpha_sum[2*CHAN_W-1:CHAN_W];
    end

    // Divider stages: restoring division, most significant quotient bit first.
    generate
        for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
            div_stage_t stage_in;
            if (g == 0) begin : g_first
                assign stage_in = num_reg;
            end else begin : g_chain
                assign stage_in = div_reg[g-1];
            end

            always_comb begin
                logic [NUM_W-1:0] shifted_den;
                div_next[g] = stage_in;
                shifted_den = '0;
                for (int b = 0; b < BITS_PER_STAGE; b++) begin
                    for (int i = 0; i < NUM_LANES; i++) begin
                        shifted_den = NUM_W'(stage_in.den)
                                    << (CHAN_W - 1 - g*BITS_PER_STAGE - b);
                        if (div_next[g].rem[i] >= shifted_den) begin
                            div_next[g].rem[i] = div_next[g].rem[i] - shifted_den;
                            div_next[g].quo[i][CHAN_W-1-g*BITS_PER_STAGE-b] = 1'b1;
                        end
                    end
                end
            end
        end
    endgenerate

    // Output stage: pack the bytes, or force zero when both alphas are zero.
    always_comb begin
        if (div_reg[DIV_STAGES-1].den == '0) begin
            m_blended_pixel_next = '0;
        end else begin
            m_blended_pixel_next = {div_reg[DIV_STAGES-1].alpha, div_reg[DIV_STAGES-1].quo};
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wgt_valid_reg <= 1'b0;
            num_valid_reg <= 1'b0;
            for (int j = 0; j < DIV_STAGES; j++) begin
                div_valid_reg[j] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (wgt_ready) begin
                wgt_valid_reg <= s_valid;
            end
            if (num_ready) begin
                num_valid_reg <= wgt_valid_reg;
            end
            if (div_ready[0]) begin
                div_valid_reg[0] <= num_valid_reg;
            end
            for (int j = 1; j < DIV_STAGES; j++) begin
                if (div_ready[j]) begin
                    div_valid_reg[j] <= div_valid_reg[j-1];
                end
            end
            if (out_ready) begin
                m_valid_reg <= div_valid_reg[DIV_STAGES-1];
            end
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge aclk) begin
        if (wgt_ready) begin
            wgt_reg <= wgt_next;
        end
        if (num_ready) begin
            num_reg <= num_next;
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (div_ready[j]) begin
                div_reg[j] <= div_next[j];
            end
        end
        if (out_ready) begin
            m_blended_pixel_reg <= m_blended_pixel_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_blended_pixel = m_blended_pixel_reg;

    // The input side stalls only when the whole pipeline is full behind a held result beat.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && wgt_valid_reg && num_valid_reg))
        else $error("input stalled while the pipeline has room");

    // A zero denominator means both alphas were zero, so every numerator is zero.
    a_zero_den_zero_num: assert property (@(posedge aclk) disable iff (!aresetn)
        (num_valid_reg && num_reg.den == '0) |-> (num_reg.rem == '0))
        else $error("nonzero color numerator with zero denominator");

    // After the last divider stage every remainder lies below the denominator.
    a_remainder_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid_reg[DIV_STAGES-1] && div_reg[DIV_STAGES-1].den != '0) |->
        ((div_reg[DIV_STAGES-1].rem[0] < NUM_W'(div_reg[DIV_STAGES-1].den)) &&
         (div_reg[DIV_STAGES-1].rem[1] < NUM_W'(div_reg[DIV_STAGES-1].den)) &&
         (div_reg[DIV_STAGES-1].rem[2] < NUM_W'(div_reg[DIV_STAGES-1].den))))
        else $error("divider remainder not below denominator");

    // A result beat held by the sink keeps its bytes until it is taken.
    a_held_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_blended_pixel)))
        else $error("held result beat changed");

endmodule

/* test/tb_rgba_over_blend_unit.sv */
// Self-checking testbench for the RGBA over blend unit with a scoreboard and random traffic.
module tb_rgba_over_blend_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rob_pkg::*;

    localparam int RANDOM_PAIRS = 1300;
    localparam int CHUNK_PAIRS  = 100;
    localparam int HOLD_CYCLES  = 60;
    localparam int BURST_PAIRS  = 40;
    localparam int SETTLE_TICKS = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 40;

    // Scoreboard that predicts each composite and compares it with the output beats.
    class blend_scoreboard;
        logic [PIX_W-1:0] composite_q[$];
        int errors;
        int checked;

        // Non-premultiplied over composite in exact integer arithmetic.
        function logic [PIX_W-1:0] over_composite(logic [PIX_W-1:0] top, logic [PIX_W-1:0] bot);
            logic [31:0] sa;
            logic [31:0] da;
            logic [31:0] den;
            logic [31:0] num;
            logic [PIX_W-1:0] pix;
            sa = 32'(top[31:24]);
            da = 32'(bot[31:24]);
            den = 32'd255 * sa + da * (32'd255 - sa);
            pix = '0;
            // Both layers fully transparent: the whole word stays zero.
            if (den != 0) begin
                pix[31:24] = 8'(den / 32'd255);
                for (int lane = 0; lane < NUM_LANES; lane++) begin
                    num = 32'd255 * sa * 32'(top[CHAN_W*lane +: CHAN_W])
                        + da * 32'(bot[CHAN_W*lane +: CHAN_W]) * (32'd255 - sa);
                    pix[CHAN_W*lane +: CHAN_W] = 8'(num / den);
                end
            end
            return pix;
        endfunction

        function void note_pair(logic [PIX_W-1:0] top, logic [PIX_W-1:0] bot);
            composite_q.push_back(over_composite(top, bot));
        endfunction

        function int pending();
            return composite_q.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_pixel(logic [PIX_W-1:0] got);
            logic [PIX_W-1:0] want;
            if (composite_q.size() == 0) begin
                report($sformatf("result beat %08h with no pair outstanding", got));
            end else begin
                want = composite_q.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("blended_pixel %08h, predicted %08h", got, want));
            end
        endtask
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [PIX_W-1:0] s_top_pixel;
    logic [PIX_W-1:0] s_bottom_pixel;
    logic             m_valid;
    logic             m_ready;
    logic [PIX_W-1:0] m_blended_pixel;

    blend_scoreboard sb = new();

    bit hold_req;
    bit rx_free;
    bit tx_steady;
    int holds_done;
    int input_stalls;
    int cycles;
    int pairs_sent;

    rgba_over_blend_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_top_pixel     (s_top_pixel),
        .s_bottom_pixel  (s_bottom_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blended_pixel (m_blended_pixel)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[rgba_over_blend_unit] ERROR");
            $finish;
        end
    end

    // Monitor both channels at each edge; inputs are noted before results are checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_pair(s_top_pixel, s_bottom_pixel);
            if (s_valid && !s_ready)
                input_stalls++;
            if (m_valid && m_ready)
                sb.check_pixel(m_blended_pixel);
        end
    end

    // Result side: random stalls, free-running stretches, and long holds on request.
    initial begin
        int pick;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end else if (rx_free) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 4)) @(posedge aclk);
                end else if (pick < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 30)) @(posedge aclk);
                end
            end
        end
    end

    // Gap before the next input beat: mostly none, sometimes short, rarely long.
    function automatic int input_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Alpha values weighted toward the corners of the blend.
    function automatic logic [7:0] pick_alpha();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'h00;
        if (r < 40)
            return 8'hFF;
        if (r < 45)
            return 8'h01;
        if (r < 50)
            return 8'hFE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] pix;
        pix = $urandom;
        if ($urandom_range(0, 9) != 0)
            pix[31:24] = pick_alpha();
        return pix;
    endfunction

    // Offer one pair and hold it until the beat is taken.
    task automatic send_pair(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] bot);
        s_valid        <= 1'b1;
        s_top_pixel    <= top;
        s_bottom_pixel <= bot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pairs_sent++;
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted composite has been seen.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Stimulus and end of run.
    initial begin
        logic [PIX_W-1:0] corner_top[18];
        logic [PIX_W-1:0] corner_bot[18];

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_top_pixel    <= '0;
        s_bottom_pixel <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: transparent pairs, opaque tops, minimal alphas and bit patterns.
        corner_top = '{32'h00000000, 32'h00FFFFFF, 32'hFF123456, 32'hFFFFFFFF,
                       32'hFF000000, 32'h00FFFFFF, 32'h00000000, 32'h01FFFFFF,
                       32'h00000000, 32'h01000000, 32'hFEFFFFFF, 32'h80FF00FF,
                       32'h7F808080, 32'hFFFFFFFF, 32'h01010101, 32'hAAAAAAAA,
                       32'h55555555, 32'hFE000000};
        corner_bot = '{32'h00000000, 32'h00FFFFFF, 32'h80ABCDEF, 32'hFFFFFFFF,
                       32'hFFFFFFFF, 32'hFF102030, 32'hFFFFFFFF, 32'h00000000,
                       32'h01FFFFFF, 32'h01FFFFFF, 32'hFF000000, 32'h8000FF00,
                       32'hFE7F7F7F, 32'h00000000, 32'hFEFEFEFE, 32'h55555555,
                       32'hAAAAAAAA, 32'h01FFFFFF};
        foreach (corner_top[i]) begin
            send_pair(corner_top[i], corner_bot[i]);
            idle_input(input_gap());
        end
        wait_drained();

        // Long hold on the result side while pairs keep coming, so the pipe backs up.
        hold_req = 1'b1;
        tx_steady = 1'b1;
        repeat (BURST_PAIRS) send_pair(random_pixel(), random_pixel());
        tx_steady = 1'b0;
        wait_drained();

        // Random traffic in chunks with changing pressure on both sides.
        for (int chunk = 0; chunk < RANDOM_PAIRS / CHUNK_PAIRS; chunk++) begin
            tx_steady = (chunk % 4 == 0);
            rx_free   = (chunk % 4 == 0) || (chunk % 5 == 2);
            if (chunk == 7)
                hold_req = 1'b1;
            repeat (CHUNK_PAIRS) begin
                send_pair(random_pixel(), random_pixel());
                idle_input(input_gap());
            end
            if (chunk % 3 == 1)
                wait_drained();
        end
        tx_steady = 1'b0;
        rx_free   = 1'b0;
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);

        $display("Sent %0d pixel pairs and checked %0d composites over %0d cycles.",
                 pairs_sent, sb.checked, cycles);
        $display("Input was held off for %0d cycles; %0d long output holds were applied.",
                 input_stalls, holds_done);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[rgba_over_blend_unit] OK");
        end else begin
            $display("%0d mismatches, %0d composites outstanding", sb.errors, sb.pending());
            $display("[rgba_over_blend_unit] ERROR");
        end
        $finish;
    end

endmodule

/* rgba_over_blend_unit.f */
rtl/rob_pkg.sv
rtl/rgba_over_blend_unit.sv
test/tb_rgba_over_blend_unit.sv
